[sv/pgt_pkg.sv]
// shared widths, pipeline latencies and helpers for the pairwise gravity terms unit
`default_nettype none
package pgt_pkg;

	localparam int PARTICLE_SLOTS = 1024;
	localparam int IDX_W          = $clog2(PARTICLE_SLOTS);
	localparam int POS_W          = 32;
	localparam int MASS_W         = 32;
	localparam int G_W            = 32;
	localparam int OUT_W          = 48;
	localparam int FRAC           = 16;
	localparam logic [G_W-1:0] G_RESET = 32'h0001_0000;
	localparam int STIFF_FACTOR   = 3;

	// separation, squared distance, mass product
	localparam int D_W  = POS_W + 1;
	localparam int SQ_W = 2 * POS_W + 2;
	localparam int K_W  = G_W + 2 * MASS_W;

	// square root of S * 2^32
	localparam int RAD_W  = SQ_W + 2 * FRAC + 1;
	localparam int ROOT_W = RAD_W / 2;

	// divider: numerator up to K*t*2^32, denominator up to S^2*R
	localparam int QW    = OUT_W;
	localparam int NUM_W = K_W + SQ_W + 2 * FRAC;
	localparam int DEN_W = 2 * SQ_W + ROOT_W;
	localparam int REM_W = DEN_W + 1;

	// multiplier built from 32x32 partial products
	localparam int LIMB   = 32;
	localparam int MUL_AW = 128;
	localparam int MUL_BW = 96;
	localparam int MUL_PW = MUL_AW + MUL_BW;

	localparam int MUL_LAT  = 3;
	localparam int SQRT_LAT = ROOT_W;
	localparam int DIV_LAT  = QW + 1;

	typedef struct packed {
		logic [QW-1:0] quo;
		logic          ovf;
	} div_res_t;

	// clamp a magnitude to the 48-bit signed range and apply the sign
	function automatic logic [OUT_W-1:0] sat_out(input logic [QW-1:0] q, input logic ovf,
			input logic neg);
		logic [OUT_W-1:0] lim;
		logic [OUT_W-1:0] mag;
		lim = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
		mag = (ovf || (OUT_W'(q) > lim)) ? lim : OUT_W'(q);
		return neg ? (~mag + OUT_W'(1)) : mag;
	endfunction

endpackage
`default_nettype wire

[sv/pgt_cfg_if.sv]
// configuration write channel carrying the gravitational constant
`default_nettype none
interface pgt_cfg_if import pgt_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [G_W-1:0] gravitational_constant;

	modport source(output valid, output gravitational_constant, input ready);
	modport sink(input valid, input gravitational_constant, output ready);
endinterface
`default_nettype wire

[sv/pgt_pair_if.sv]
// input channel: one particle pair per item
`default_nettype none
interface pgt_pair_if import pgt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        first_index;
	logic [IDX_W-1:0]        second_index;
	logic signed [POS_W-1:0] first_pos_x;
	logic signed [POS_W-1:0] first_pos_y;
	logic signed [POS_W-1:0] second_pos_x;
	logic signed [POS_W-1:0] second_pos_y;
	logic [MASS_W-1:0]       first_mass;
	logic [MASS_W-1:0]       second_mass;

	modport source(output valid, output first_index, output second_index,
		output first_pos_x, output first_pos_y, output second_pos_x, output second_pos_y,
		output first_mass, output second_mass, input ready);
	modport sink(input valid, input first_index, input second_index,
		input first_pos_x, input first_pos_y, input second_pos_x, input second_pos_y,
		input first_mass, input second_mass, output ready);
endinterface
`default_nettype wire

[sv/pgt_term_if.sv]
// output channel: energy, force and stiffness terms of one pair per item
`default_nettype none
interface pgt_term_if import pgt_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        pair_first;
	logic [IDX_W-1:0]        pair_second;
	logic signed [OUT_W-1:0] energy_term;
	logic signed [OUT_W-1:0] force_x;
	logic signed [OUT_W-1:0] force_y;
	logic signed [OUT_W-1:0] stiff_xx;
	logic signed [OUT_W-1:0] stiff_xy;
	logic signed [OUT_W-1:0] stiff_yy;
	logic                    coincident;

	modport source(output valid, output pair_first, output pair_second, output energy_term,
		output force_x, output force_y, output stiff_xx, output stiff_xy, output stiff_yy,
		output coincident, input ready);
	modport sink(input valid, input pair_first, input pair_second, input energy_term,
		input force_x, input force_y, input stiff_xx, input stiff_xy, input stiff_yy,
		input coincident, output ready);
endinterface
`default_nettype wire

[sv/pgt_mul.sv]
// three-stage unsigned multiplier built from 32x32 partial products
`default_nettype none
module pgt_mul import pgt_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [MUL_AW-1:0] a,
	input  logic [MUL_BW-1:0] b,
	output logic [MUL_PW-1:0] p
);
	localparam int AL    = MUL_AW / LIMB;
	localparam int BL    = MUL_BW / LIMB;
	localparam int ROW_W = MUL_AW + LIMB;

	logic [2*LIMB-1:0] pp_s1 [0:AL-1][0:BL-1];
	logic [ROW_W-1:0]  row_s2 [0:BL-1];
	logic [MUL_PW-1:0] p_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < AL; i++) begin
				for (int j = 0; j < BL; j++) begin
					pp_s1[i][j] <= a[LIMB*i +: LIMB] * b[LIMB*j +: LIMB];
				end
			end
		end
	end

	// even and odd limb products do not overlap, so each row is one add
	always_ff @(posedge clk) begin
		logic [ROW_W-1:0] ev;
		logic [ROW_W-1:0] od;
		if (en) begin
			for (int j = 0; j < BL; j++) begin
				ev = '0;
				od = '0;
				for (int i = 0; i < AL; i++) begin
					if (i % 2 == 0) begin
						ev[LIMB*i +: 2*LIMB] = pp_s1[i][j];
					end else begin
						od[LIMB*i +: 2*LIMB] = pp_s1[i][j];
					end
				end
				row_s2[j] <= ev + od;
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [MUL_PW-1:0] acc;
		if (en) begin
			acc = '0;
			for (int j = 0; j < BL; j++) begin
				acc = acc + (MUL_PW'(row_s2[j]) << (LIMB * j));
			end
			p_s3 <= acc;
		end
	end

	assign p = p_s3;
endmodule
`default_nettype wire

[sv/pgt_sqrt.sv]
// pipelined integer square root, one root bit per stage
`default_nettype none
module pgt_sqrt import pgt_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);
	logic [RAD_W-1:0] num_s [1:ROOT_W];
	logic [RAD_W-1:0] res_s [1:ROOT_W];

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_st
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (ROOT_W - k));
		logic [RAD_W-1:0] num_p;
		logic [RAD_W-1:0] res_p;
		logic [RAD_W-1:0] trial;

		if (k == 1) begin : g_first
			assign num_p = rad;
			assign res_p = '0;
		end else begin : g_next
			assign num_p = num_s[k-1];
			assign res_p = res_s[k-1];
		end

		assign trial = res_p + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (num_p >= trial) begin
					num_s[k] <= num_p - trial;
					res_s[k] <= (res_p >> 1) + BIT;
				end else begin
					num_s[k] <= num_p;
					res_s[k] <= res_p >> 1;
				end
			end
		end
	end

	assign root = res_s[ROOT_W][ROOT_W-1:0];
endmodule
`default_nettype wire

[sv/pgt_div.sv]
// pipelined restoring divider, 48 quotient bits plus overflow flag
`default_nettype none
module pgt_div import pgt_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output div_res_t         res
);
	logic [REM_W-1:0] rem_s [0:QW];
	logic [DEN_W-1:0] den_s [0:QW];
	logic [QW-1:0]    lq_s  [0:QW];
	logic             ovf_s [0:QW];

	// quotient at or above 2^48 when the upper numerator already reaches den
	always_ff @(posedge clk) begin
		logic hi_ge;
		if (en) begin
			hi_ge    = REM_W'(num[NUM_W-1:QW]) >= REM_W'(den);
			ovf_s[0] <= hi_ge;
			rem_s[0] <= hi_ge ? '0 : REM_W'(num[NUM_W-1:QW]);
			lq_s[0]  <= num[QW-1:0];
			den_s[0] <= den;
		end
	end

	// low numerator bits shift out while quotient bits shift in
	for (genvar k = 1; k <= QW; k++) begin : g_st
		logic [REM_W-1:0] t;
		logic [REM_W-1:0] dz;

		assign t  = {rem_s[k-1][REM_W-2:0], lq_s[k-1][QW-1]};
		assign dz = {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				if (t >= dz) begin
					rem_s[k] <= t - dz;
					lq_s[k]  <= {lq_s[k-1][QW-2:0], 1'b1};
				end else begin
					rem_s[k] <= t;
					lq_s[k]  <= {lq_s[k-1][QW-2:0], 1'b0};
				end
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign res.quo = lq_s[QW];
	assign res.ovf = ovf_s[QW];
endmodule
`default_nettype wire

[sv/pairwise_gravity_terms_unit.sv]
// top level: pairwise newtonian gravity energy, force and stiffness pipeline
`default_nettype none
// Takes one particle pair per clock unless held, and gives the potential
// energy -K/r, the force K*d/r^3 and the 2x2 stiffness (I - 3nn^T)K/r^3 with
// K = G*m1*m2, all signed Q32.16 and saturated; indices are echoed, and a pair
// at zero distance raises coincident with all terms zero. Sustained rate is one
// item per cycle unless the output buffer is full. Latency is set by the 49-stage
// square root followed by the 49-stage dividers and three 3-stage multiplier
// steps. A two-entry output buffer sits behind the pipeline: the whole pipeline
// holds only while that buffer is full, so results keep flowing while one waits
// to be taken. G is written through cfg and sampled when an item enters.
module pairwise_gravity_terms_unit import pgt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pgt_cfg_if.sink     cfg,
	pgt_pair_if.sink    pairs,
	pgt_term_if.source  terms
);
	// stage numbers where fields become valid
	localparam int ST_ABS  = 3;
	localparam int ST_SUM  = ST_ABS + MUL_LAT + 1;
	localparam int ST_T    = ST_SUM + 1;
	localparam int ST_KL   = ST_ABS + MUL_LAT;
	localparam int ST_K    = ST_KL + MUL_LAT + 1;
	localparam int ST_ROOT = ST_SUM + SQRT_LAT + 1;
	localparam int ST_L2   = ST_ROOT + MUL_LAT;
	localparam int ST_L3   = ST_L2 + MUL_LAT;
	localparam int ST_E    = ST_ROOT + DIV_LAT + 1;
	localparam int ST_F    = ST_L2 + DIV_LAT + 1;
	localparam int ST_S    = ST_L3 + DIV_LAT + 1;
	localparam int LAST    = ST_S;
	localparam int OB_DEPTH = 2;

	typedef struct packed {
		logic [IDX_W-1:0]      ia;
		logic [IDX_W-1:0]      ib;
		logic [POS_W-1:0]      p1x;
		logic [POS_W-1:0]      p1y;
		logic [POS_W-1:0]      p2x;
		logic [POS_W-1:0]      p2y;
		logic [MASS_W-1:0]     m1;
		logic [MASS_W-1:0]     m2;
		logic [G_W-1:0]        g;
		logic signed [D_W-1:0] dx;
		logic signed [D_W-1:0] dy;
		logic [D_W-1:0]        ax;
		logic [D_W-1:0]        ay;
		logic                  sgnx;
		logic                  sgny;
		logic                  coin;
		logic                  negx;
		logic                  negy;
		logic [SQ_W-1:0]       s;
		logic [SQ_W-1:0]       tx3;
		logic [SQ_W-1:0]       ty3;
		logic [SQ_W-1:0]       axy3;
		logic [SQ_W-1:0]       tx;
		logic [SQ_W-1:0]       ty;
		logic [K_W-1:0]        k;
		logic [ROOT_W-1:0]     root;
		div_res_t              e;
		div_res_t              fx;
		div_res_t              fy;
		div_res_t              sxx;
		div_res_t              syy;
		div_res_t              sxy;
	} side_t;

	typedef struct packed {
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic [OUT_W-1:0] e;
		logic [OUT_W-1:0] fx;
		logic [OUT_W-1:0] fy;
		logic [OUT_W-1:0] sxx;
		logic [OUT_W-1:0] sxy;
		logic [OUT_W-1:0] syy;
		logic             coin;
	} term_t;

	logic [G_W-1:0] g_q;
	logic           en;
	logic           acc;
	logic           push;
	logic           pop;
	logic           to_head;
	logic [1:0]     cnt_q;
	side_t          ent_d;
	side_t          sd_s [1:LAST];
	side_t          sd_d [2:LAST];
	logic [1:LAST]  vld_s;
	term_t          ob_q [0:OB_DEPTH-1];
	term_t          term_d;

	// multiplier, square root and divider results
	logic [MUL_PW-1:0] ax2_p, ay2_p, axy_p, gm_p, k_p;
	logic [MUL_PW-1:0] den_p, kx_p, ky_p, den2_p, kxx_p, kyy_p, kxy_p;
	logic [ROOT_W-1:0] root_w;
	div_res_t          e_res, fx_res, fy_res, sxx_res, syy_res, sxy_res;

	// configuration register, always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q <= G_RESET;
		end else if (cfg.valid && cfg.ready) begin
			g_q <= cfg.gravitational_constant;
		end
	end

	// the whole pipeline advances together unless the output buffer is full
	assign en          = (cnt_q != 2'(OB_DEPTH));
	assign pairs.ready = en;
	assign acc         = pairs.valid && pairs.ready;
	assign push        = en && vld_s[LAST];
	assign pop         = terms.valid && terms.ready;

	always_comb begin
		ent_d     = '0;
		ent_d.ia  = pairs.first_index;
		ent_d.ib  = pairs.second_index;
		ent_d.p1x = pairs.first_pos_x;
		ent_d.p1y = pairs.first_pos_y;
		ent_d.p2x = pairs.second_pos_x;
		ent_d.p2y = pairs.second_pos_y;
		ent_d.m1  = pairs.first_mass;
		ent_d.m2  = pairs.second_mass;
		ent_d.g   = g_q;
	end

	// valid bits travel with the side data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {acc, vld_s[1:LAST-1]};
		end
	end

	// side data: copied forward every stage, fields filled where they are produced
	always_comb begin
		for (int k = 2; k <= LAST; k++) begin
			sd_d[k] = sd_s[k-1];
		end

		// separation, sign-extended to 33 bits
		sd_d[2].dx = $signed({sd_s[1].p2x[POS_W-1], sd_s[1].p2x})
			- $signed({sd_s[1].p1x[POS_W-1], sd_s[1].p1x});
		sd_d[2].dy = $signed({sd_s[1].p2y[POS_W-1], sd_s[1].p2y})
			- $signed({sd_s[1].p1y[POS_W-1], sd_s[1].p1y});

		// magnitudes and signs
		sd_d[ST_ABS].ax   = sd_s[ST_ABS-1].dx[D_W-1] ? D_W'(-sd_s[ST_ABS-1].dx)
			: D_W'(sd_s[ST_ABS-1].dx);
		sd_d[ST_ABS].ay   = sd_s[ST_ABS-1].dy[D_W-1] ? D_W'(-sd_s[ST_ABS-1].dy)
			: D_W'(sd_s[ST_ABS-1].dy);
		sd_d[ST_ABS].sgnx = sd_s[ST_ABS-1].dx[D_W-1];
		sd_d[ST_ABS].sgny = sd_s[ST_ABS-1].dy[D_W-1];
		sd_d[ST_ABS].coin = (sd_s[ST_ABS-1].dx == '0) && (sd_s[ST_ABS-1].dy == '0);

		// squared distance and the 3*a^2 terms
		sd_d[ST_SUM].s    = SQ_W'(ax2_p) + SQ_W'(ay2_p);
		sd_d[ST_SUM].tx3  = SQ_W'(ax2_p) * SQ_W'(STIFF_FACTOR);
		sd_d[ST_SUM].ty3  = SQ_W'(ay2_p) * SQ_W'(STIFF_FACTOR);
		sd_d[ST_SUM].axy3 = SQ_W'(axy_p) * SQ_W'(STIFF_FACTOR);

		// |S - 3a^2| with its sign for the diagonal entries
		if (sd_s[ST_T-1].tx3 > sd_s[ST_T-1].s) begin
			sd_d[ST_T].tx   = sd_s[ST_T-1].tx3 - sd_s[ST_T-1].s;
			sd_d[ST_T].negx = 1'b1;
		end else begin
			sd_d[ST_T].tx   = sd_s[ST_T-1].s - sd_s[ST_T-1].tx3;
			sd_d[ST_T].negx = 1'b0;
		end
		if (sd_s[ST_T-1].ty3 > sd_s[ST_T-1].s) begin
			sd_d[ST_T].ty   = sd_s[ST_T-1].ty3 - sd_s[ST_T-1].s;
			sd_d[ST_T].negy = 1'b1;
		end else begin
			sd_d[ST_T].ty   = sd_s[ST_T-1].s - sd_s[ST_T-1].ty3;
			sd_d[ST_T].negy = 1'b0;
		end

		sd_d[ST_K].k       = K_W'(k_p);
		sd_d[ST_ROOT].root = root_w;
		sd_d[ST_E].e       = e_res;
		sd_d[ST_F].fx      = fx_res;
		sd_d[ST_F].fy      = fy_res;
		sd_d[ST_S].sxx     = sxx_res;
		sd_d[ST_S].syy     = syy_res;
		sd_d[ST_S].sxy     = sxy_res;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[1] <= ent_d;
			for (int k = 2; k <= LAST; k++) begin
				sd_s[k] <= sd_d[k];
			end
		end
	end

	// squares, cross product and G*m1
	pgt_mul u_ax2 (.clk, .en, .a(MUL_AW'(sd_s[ST_ABS].ax)), .b(MUL_BW'(sd_s[ST_ABS].ax)),
		.p(ax2_p));
	pgt_mul u_ay2 (.clk, .en, .a(MUL_AW'(sd_s[ST_ABS].ay)), .b(MUL_BW'(sd_s[ST_ABS].ay)),
		.p(ay2_p));
	pgt_mul u_axy (.clk, .en, .a(MUL_AW'(sd_s[ST_ABS].ax)), .b(MUL_BW'(sd_s[ST_ABS].ay)),
		.p(axy_p));
	pgt_mul u_gm (.clk, .en, .a(MUL_AW'(sd_s[ST_ABS].g)), .b(MUL_BW'(sd_s[ST_ABS].m1)),
		.p(gm_p));

	// K = G*m1*m2
	pgt_mul u_k (.clk, .en, .a(MUL_AW'(gm_p[2*G_W-1:0])), .b(MUL_BW'(sd_s[ST_KL].m2)),
		.p(k_p));

	// R = floor(sqrt(S * 2^32))
	pgt_sqrt u_sqrt (.clk, .en, .rad(RAD_W'({sd_s[ST_SUM].s, {(2*FRAC){1'b0}}})),
		.root(root_w));

	// energy: K / R
	pgt_div u_div_e (.clk, .en, .num(NUM_W'(sd_s[ST_ROOT].k)),
		.den(DEN_W'(sd_s[ST_ROOT].root)), .res(e_res));

	// S*R and the force numerators
	pgt_mul u_den (.clk, .en, .a(MUL_AW'(sd_s[ST_ROOT].s)), .b(MUL_BW'(sd_s[ST_ROOT].root)),
		.p(den_p));
	pgt_mul u_kx (.clk, .en, .a(MUL_AW'(sd_s[ST_ROOT].k)), .b(MUL_BW'(sd_s[ST_ROOT].ax)),
		.p(kx_p));
	pgt_mul u_ky (.clk, .en, .a(MUL_AW'(sd_s[ST_ROOT].k)), .b(MUL_BW'(sd_s[ST_ROOT].ay)),
		.p(ky_p));

	// force: K*a*2^16 / (S*R)
	pgt_div u_div_fx (.clk, .en,
		.num(NUM_W'({kx_p[K_W+D_W-1:0], {FRAC{1'b0}}})),
		.den(DEN_W'(den_p[2*SQ_W-1:0])), .res(fx_res));
	pgt_div u_div_fy (.clk, .en,
		.num(NUM_W'({ky_p[K_W+D_W-1:0], {FRAC{1'b0}}})),
		.den(DEN_W'(den_p[2*SQ_W-1:0])), .res(fy_res));

	// S^2*R and the stiffness numerators
	pgt_mul u_den2 (.clk, .en, .a(MUL_AW'(den_p[2*SQ_W-1:0])), .b(MUL_BW'(sd_s[ST_L2].s)),
		.p(den2_p));
	pgt_mul u_kxx (.clk, .en, .a(MUL_AW'(sd_s[ST_L2].k)), .b(MUL_BW'(sd_s[ST_L2].tx)),
		.p(kxx_p));
	pgt_mul u_kyy (.clk, .en, .a(MUL_AW'(sd_s[ST_L2].k)), .b(MUL_BW'(sd_s[ST_L2].ty)),
		.p(kyy_p));
	pgt_mul u_kxy (.clk, .en, .a(MUL_AW'(sd_s[ST_L2].k)), .b(MUL_BW'(sd_s[ST_L2].axy3)),
		.p(kxy_p));

	// stiffness: K*t*2^32 / (S^2*R)
	pgt_div u_div_sxx (.clk, .en, .num({kxx_p[K_W+SQ_W-1:0], {(2*FRAC){1'b0}}}),
		.den(den2_p[DEN_W-1:0]), .res(sxx_res));
	pgt_div u_div_syy (.clk, .en, .num({kyy_p[K_W+SQ_W-1:0], {(2*FRAC){1'b0}}}),
		.den(den2_p[DEN_W-1:0]), .res(syy_res));
	pgt_div u_div_sxy (.clk, .en, .num({kxy_p[K_W+SQ_W-1:0], {(2*FRAC){1'b0}}}),
		.den(den2_p[DEN_W-1:0]), .res(sxy_res));

	// signs, saturation and the zero-distance case
	always_comb begin
		term_d      = '0;
		term_d.a    = sd_s[LAST].ia;
		term_d.b    = sd_s[LAST].ib;
		term_d.coin = sd_s[LAST].coin;
		if (!sd_s[LAST].coin) begin
			term_d.e   = sat_out(sd_s[LAST].e.quo, sd_s[LAST].e.ovf, 1'b1);
			term_d.fx  = sat_out(sd_s[LAST].fx.quo, sd_s[LAST].fx.ovf, sd_s[LAST].sgnx);
			term_d.fy  = sat_out(sd_s[LAST].fy.quo, sd_s[LAST].fy.ovf, sd_s[LAST].sgny);
			term_d.sxx = sat_out(sd_s[LAST].sxx.quo, sd_s[LAST].sxx.ovf, sd_s[LAST].negx);
			term_d.syy = sat_out(sd_s[LAST].syy.quo, sd_s[LAST].syy.ovf, sd_s[LAST].negy);
			term_d.sxy = sat_out(sd_s[LAST].sxy.quo, sd_s[LAST].sxy.ovf,
				sd_s[LAST].sgnx == sd_s[LAST].sgny);
		end
	end

	// two-entry output buffer, head in slot 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// a new item lands at the head when the buffer is or becomes empty
	assign to_head = push && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));

	always_ff @(posedge clk) begin
		if (to_head) begin
			ob_q[0] <= term_d;
		end else if (pop) begin
			ob_q[0] <= ob_q[1];
		end
		if (push && !to_head) begin
			ob_q[1] <= term_d;
		end
	end

	assign terms.valid       = (cnt_q != 2'd0);
	assign terms.pair_first  = ob_q[0].a;
	assign terms.pair_second = ob_q[0].b;
	assign terms.energy_term = $signed(ob_q[0].e);
	assign terms.force_x     = $signed(ob_q[0].fx);
	assign terms.force_y     = $signed(ob_q[0].fy);
	assign terms.stiff_xx    = $signed(ob_q[0].sxx);
	assign terms.stiff_xy    = $signed(ob_q[0].sxy);
	assign terms.stiff_yy    = $signed(ob_q[0].syy);
	assign terms.coincident  = ob_q[0].coin;

	// buffer occupancy never exceeds its depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(OB_DEPTH))
		else $error("output buffer overfilled");

	// a held pipeline keeps every in-flight item
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("pipeline moved while held");

	// coincident pairs carry all-zero terms
	a_coin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		terms.valid && terms.coincident |-> terms.energy_term == '0 && terms.force_x == '0
		&& terms.force_y == '0 && terms.stiff_xx == '0 && terms.stiff_xy == '0
		&& terms.stiff_yy == '0)
		else $error("coincident item with nonzero terms");

	// potential energy is never positive
	a_energy_sign: assert property (@(posedge clk) disable iff (!arst_n)
		terms.valid |-> (terms.energy_term[OUT_W-1] || terms.energy_term == '0))
		else $error("positive energy term");
endmodule
`default_nettype wire

[tb/pairwise_gravity_terms_unit_tb.sv]
// self-checking testbench for the pairwise gravity terms unit
`default_nettype none
module pairwise_gravity_terms_unit_tb;
	import pgt_pkg::*;

	// one particle pair as offered on the input channel
	typedef struct {
		logic [IDX_W-1:0]        first_index;
		logic [IDX_W-1:0]        second_index;
		logic signed [POS_W-1:0] first_pos_x;
		logic signed [POS_W-1:0] first_pos_y;
		logic signed [POS_W-1:0] second_pos_x;
		logic signed [POS_W-1:0] second_pos_y;
		logic [MASS_W-1:0]       first_mass;
		logic [MASS_W-1:0]       second_mass;
	} pair_t;

	// the terms of one pair as given on the output channel
	typedef struct packed {
		logic [IDX_W-1:0] pair_first;
		logic [IDX_W-1:0] pair_second;
		logic [OUT_W-1:0] energy_term;
		logic [OUT_W-1:0] force_x;
		logic [OUT_W-1:0] force_y;
		logic [OUT_W-1:0] stiff_xx;
		logic [OUT_W-1:0] stiff_xy;
		logic [OUT_W-1:0] stiff_yy;
		logic             coincident;
	} terms_t;

	typedef logic [255:0] wide_t;

	localparam int MAX_REPORTS = 10;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 200;

	// keeps the expected terms of accepted pairs in order of acceptance
	class gravity_scoreboard;
		terms_t      pending_terms[$];
		logic [31:0] grav_const;
		int          mismatches;

		function new();
			grav_const = G_RESET;
			mismatches = 0;
		endfunction

		// clamp a magnitude to 48 bits signed and apply the sign
		function logic [OUT_W-1:0] clamp48(wide_t q, bit neg);
			wide_t            lim;
			logic [OUT_W-1:0] val;
			lim = neg ? (wide_t'(1) << 47) : ((wide_t'(1) << 47) - 1);
			val = (q > lim) ? lim[OUT_W-1:0] : q[OUT_W-1:0];
			return (neg && q != 0) ? (~val + 1'b1) : val;
		endfunction

		// diagonal stiffness entry: K*(S - 3a^2)*2^32 / (S^2*R)
		function logic [OUT_W-1:0] stiff_diag(wide_t k, wide_t s, wide_t a, wide_t den2);
			wide_t t3;
			wide_t t;
			bit    neg;
			t3 = wide_t'(STIFF_FACTOR) * a * a;
			if (s >= t3) begin
				t = s - t3;
				neg = 0;
			end else begin
				t = t3 - s;
				neg = 1;
			end
			return clamp48(((k * t) << 32) / den2, neg);
		endfunction

		function terms_t gravity_terms(pair_t p);
			terms_t             e;
			logic signed [33:0] dx;
			logic signed [33:0] dy;
			wide_t              ax;
			wide_t              ay;
			wide_t              s;
			wide_t              k;
			wide_t              rad;
			wide_t              root;
			wide_t              cand;
			wide_t              den;
			wide_t              den2;
			dx = 34'(p.second_pos_x) - 34'(p.first_pos_x);
			dy = 34'(p.second_pos_y) - 34'(p.first_pos_y);
			ax = wide_t'(dx < 0 ? -dx : dx);
			ay = wide_t'(dy < 0 ? -dy : dy);
			e = '{default: '0};
			e.pair_first = p.first_index;
			e.pair_second = p.second_index;
			if (ax == 0 && ay == 0) begin
				e.coincident = 1'b1;
				return e;
			end
			s = ax * ax + ay * ay;
			k = wide_t'(grav_const) * wide_t'(p.first_mass) * wide_t'(p.second_mass);
			// integer square root of S * 2^32, one bit per step
			rad = s << 32;
			root = 0;
			for (int b = 63; b >= 0; b--) begin
				cand = root | (wide_t'(1) << b);
				if (cand * cand <= rad)
					root = cand;
			end
			den = s * root;
			den2 = den * s;
			e.energy_term = clamp48(k / root, 1);
			e.force_x = clamp48(((k * ax) << 16) / den, dx < 0);
			e.force_y = clamp48(((k * ay) << 16) / den, dy < 0);
			e.stiff_xx = stiff_diag(k, s, ax, den2);
			e.stiff_yy = stiff_diag(k, s, ay, den2);
			e.stiff_xy = clamp48(((k * ax * ay * STIFF_FACTOR) << 32) / den2,
				(dx < 0) == (dy < 0));
			return e;
		endfunction

		function void note_pair(pair_t p);
			pending_terms.push_back(gravity_terms(p));
		endfunction

		function void check_terms(terms_t got);
			terms_t e;
			if (pending_terms.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result item, pair %0d/%0d", got.pair_first,
						got.pair_second);
				return;
			end
			e = pending_terms.pop_front();
			if (got != e) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("mismatch pair %0d/%0d: expected e=%h fx=%h fy=%h xx=%h xy=%h yy=%h c=%b",
						e.pair_first, e.pair_second, e.energy_term, e.force_x, e.force_y,
						e.stiff_xx, e.stiff_xy, e.stiff_yy, e.coincident);
					$display("  actual pair %0d/%0d: e=%h fx=%h fy=%h xx=%h xy=%h yy=%h c=%b",
						got.pair_first, got.pair_second, got.energy_term, got.force_x,
						got.force_y, got.stiff_xx, got.stiff_xy, got.stiff_yy, got.coincident);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pgt_cfg_if  cfg();
	pgt_pair_if pairs();
	pgt_term_if terms();

	pairwise_gravity_terms_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg.sink),
		.pairs  (pairs.sink),
		.terms  (terms.source)
	);

	gravity_scoreboard sb = new();
	int results_seen = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// generous fixed limit on the whole run
	initial begin
		#20000000;
		$display("pairwise_gravity_terms_unit test failed");
		$finish;
	end

	// gap length: mostly none, sometimes short, rarely long
	function int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// every result item is checked against the oldest expectation
	always @(posedge clk) begin
		terms_t got;
		if (arst_n && terms.valid && terms.ready) begin
			got.pair_first = terms.pair_first;
			got.pair_second = terms.pair_second;
			got.energy_term = terms.energy_term;
			got.force_x = terms.force_x;
			got.force_y = terms.force_y;
			got.stiff_xx = terms.stiff_xx;
			got.stiff_xy = terms.stiff_xy;
			got.stiff_yy = terms.stiff_yy;
			got.coincident = terms.coincident;
			sb.check_terms(got);
			results_seen++;
		end
	end

	// receiver: random back-pressure plus one long hold-off that fills the pipeline
	initial begin
		int  stall_left;
		int  free_left;
		bit  held;
		stall_left = 0;
		free_left = 0;
		held = 0;
		terms.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && results_seen >= 300) begin
				held = 1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				terms.ready <= 1'b0;
			end else if (free_left > 0) begin
				free_left--;
				terms.ready <= 1'b1;
			end else begin
				stall_left = gap_cycles();
				if ($urandom_range(0, 49) == 0)
					free_left = $urandom_range(50, 200);
				terms.ready <= (stall_left == 0);
			end
		end
	end

	task automatic send_pair(pair_t p);
		int gap;
		pairs.valid <= 1'b1;
		pairs.first_index <= p.first_index;
		pairs.second_index <= p.second_index;
		pairs.first_pos_x <= p.first_pos_x;
		pairs.first_pos_y <= p.first_pos_y;
		pairs.second_pos_x <= p.second_pos_x;
		pairs.second_pos_y <= p.second_pos_y;
		pairs.first_mass <= p.first_mass;
		pairs.second_mass <= p.second_mass;
		do
			@(posedge clk);
		while (!pairs.ready);
		sb.note_pair(p);
		gap = gap_cycles();
		if (gap > 0) begin
			pairs.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_fields(int fi, int si, int x1, int y1, int x2, int y2,
			logic [31:0] m1, logic [31:0] m2);
		pair_t p;
		p.first_index = IDX_W'(fi);
		p.second_index = IDX_W'(si);
		p.first_pos_x = x1;
		p.first_pos_y = y1;
		p.second_pos_x = x2;
		p.second_pos_y = y2;
		p.first_mass = m1;
		p.second_mass = m2;
		send_pair(p);
	endtask

	// random pair: mostly nearby particles at a random scale so terms stay in range
	task automatic send_random_pair();
		pair_t p;
		int    mode;
		int    sh;
		p.first_index = IDX_W'($urandom);
		p.second_index = IDX_W'($urandom);
		p.first_pos_x = $urandom;
		p.first_pos_y = $urandom;
		p.first_mass = $urandom >> $urandom_range(0, 31);
		p.second_mass = $urandom >> $urandom_range(0, 31);
		mode = $urandom_range(0, 19);
		sh = $urandom_range(0, 31);
		if (mode < 3) begin
			p.second_pos_x = $urandom;
			p.second_pos_y = $urandom;
			p.first_mass = $urandom;
			p.second_mass = $urandom;
		end else if (mode == 3) begin
			// coincident pair
			p.second_pos_x = p.first_pos_x;
			p.second_pos_y = p.first_pos_y;
		end else begin
			p.second_pos_x = p.first_pos_x + ($signed($urandom) >>> sh);
			p.second_pos_y = p.first_pos_y + ($signed($urandom) >>> $urandom_range(0, 31));
		end
		send_pair(p);
	endtask

	// write G while the block is idle
	task automatic write_gravity(logic [31:0] g);
		pairs.valid <= 1'b0;
		while (sb.pending_terms.size() != 0)
			@(posedge clk);
		repeat (130) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.gravitational_constant <= g;
		do
			@(posedge clk);
		while (!cfg.ready);
		sb.grav_const = g;
		cfg.valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] g_values[5];
		int          deadline;
		g_values = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'h0001_0000};
		g_values[3] = $urandom;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.gravitational_constant = '0;
		pairs.valid = 1'b0;
		pairs.first_index = '0;
		pairs.second_index = '0;
		pairs.first_pos_x = '0;
		pairs.first_pos_y = '0;
		pairs.second_pos_x = '0;
		pairs.second_pos_y = '0;
		pairs.first_mass = '0;
		pairs.second_mass = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pairs at the reset value of G
		send_fields(0, 1023, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000);      // coincident
		send_fields(5, 5, 100, -7, 100, -7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // coincident, equal indices
		send_fields(1, 2, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 32'h0001_0000);  // unit x
		send_fields(3, 4, 0, 0, 0, -32'sh0001_0000, 32'h0001_0000, 32'h0002_0000); // unit -y
		send_fields(6, 7, 0, 0, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'h0001_0000);
		send_fields(8, 9, 0, 0, -32'sh0003_0000, 32'h0004_0000, 32'h0005_0000, 32'h0001_0000);
		send_fields(1023, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);                                      // widest separation
		send_fields(512, 511, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 32'h0001_0000, 32'h0001_0000);
		send_fields(10, 11, 0, 0, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);       // tiny distance, saturates
		send_fields(12, 13, 0, 0, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_fields(14, 15, 0, 0, -1, 1, 32'h0000_0001, 32'h0000_0001);
		send_fields(16, 17, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 32'hFFFF_FFFF); // zero mass
		send_fields(18, 19, 32'h0010_0000, 0, 0, 32'h0010_0000, 32'hFFFF_FFFF, 0);
		send_fields(20, 21, -5, -5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0000_FFFF);
		send_fields(22, 23, 0, 0, 32'h0000_8000, -32'sh0000_8000, 32'h0100_0000, 32'h0100_0000);
		repeat (250) send_random_pair();

		// further settings of G, extremes among them
		foreach (g_values[i]) begin
			write_gravity(g_values[i]);
			if (i == 2)
				send_fields(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001);
			if (i == 1)
				send_fields(1, 1, 0, 0, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
			repeat (240) send_random_pair();
		end
		pairs.valid <= 1'b0;

		// drain, then a quiet stretch to catch stray results
		deadline = 0;
		while (sb.pending_terms.size() != 0 && deadline < 100000) begin
			@(posedge clk);
			deadline++;
		end
		if (sb.pending_terms.size() != 0) begin
			$display("pairwise_gravity_terms_unit test failed");
			$finish;
		end else begin
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (sb.mismatches == 0)
				$display("pairwise_gravity_terms_unit test passed");
			else
				$display("pairwise_gravity_terms_unit test failed");
			$finish;
		end
	end

endmodule
`default_nettype wire

[sim.f]
sv/pgt_pkg.sv
sv/pgt_cfg_if.sv
sv/pgt_pair_if.sv
sv/pgt_term_if.sv
sv/pgt_mul.sv
sv/pgt_sqrt.sv
sv/pgt_div.sv
sv/pairwise_gravity_terms_unit.sv
tb/pairwise_gravity_terms_unit_tb.sv
